@@ hdl/pfd_pkg.sv @@
// Shared types, constants, microcode table and helpers for the PID controller.
package pfd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int COEF_W     = 32;
  localparam int POLE_W     = FRAC_W + 1;
  localparam int DRIVE_W    = 16;
  localparam int ACC_W      = 48;
  localparam int WIDE_W     = ACC_W + 4;
  localparam int HALF_W     = WIDE_W / 2;
  localparam int PROD_W     = WIDE_W + COEF_W;
  localparam int LIM_W      = DRIVE_W + FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PC_W       = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN = 3'd0,
    REG_KI_TS     = 3'd1,
    REG_POLE      = 3'd2,
    REG_KD        = 3'd3,
    REG_KB        = 3'd4,
    REG_LOWER     = 3'd5,
    REG_UPPER     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  kp;
    logic signed [COEF_W-1:0]  ki;
    logic        [POLE_W-1:0]  pole;
    logic signed [COEF_W-1:0]  kd;
    logic signed [COEF_W-1:0]  kb;
    logic signed [DRIVE_W-1:0] lower;
    logic signed [DRIVE_W-1:0] upper;
  } cfg_t;

  typedef enum logic [2:0] {
    MOP_NOP,
    MOP_LD,
    MOP_MLO,
    MOP_MHI,
    MOP_FIN
  } mop_t;

  typedef enum logic [3:0] {
    AOP_NOP,
    AOP_SET,
    AOP_ADD,
    AOP_DSAT,
    AOP_CLAMP,
    AOP_DIFF,
    AOP_ISUM,
    AOP_COMMIT,
    AOP_HOLD
  } aop_t;

  typedef enum logic [1:0] {
    ASEL_FD,
    ASEL_DERR,
    ASEL_E,
    ASEL_ACC
  } asel_t;

  typedef enum logic [2:0] {
    BSEL_ALPHA,
    BSEL_KD,
    BSEL_KP,
    BSEL_KI,
    BSEL_KB
  } bsel_t;

  typedef struct packed {
    mop_t            mop;
    asel_t           asel;
    bsel_t           bsel;
    logic            frac_shift;
    aop_t            aop;
    logic            jump_inv;
    logic [PC_W-1:0] target;
    logic            done;
  } ucw_t;

  localparam logic [PC_W-1:0] PC_HOLD = 5'd18;

  localparam ucw_t UCW_NOP = '{
    mop: MOP_NOP, asel: ASEL_FD, bsel: BSEL_ALPHA, frac_shift: 1'b0,
    aop: AOP_NOP, jump_inv: 1'b0, target: {PC_W{1'b0}}, done: 1'b0
  };

  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = UCW_NOP;
    case (pc)
      5'd0: begin
        w.mop = MOP_LD; w.asel = ASEL_FD; w.bsel = BSEL_ALPHA; w.frac_shift = 1'b1;
        w.jump_inv = 1'b1; w.target = PC_HOLD;
      end
      5'd1: w.mop = MOP_MLO;
      5'd2: w.mop = MOP_MHI;
      5'd3: w.mop = MOP_FIN;
      5'd4: begin
        w.mop = MOP_LD; w.asel = ASEL_DERR; w.bsel = BSEL_KD; w.aop = AOP_SET;
      end
      5'd5: w.mop = MOP_MLO;
      5'd6: w.mop = MOP_FIN;
      5'd7: begin
        w.mop = MOP_LD; w.asel = ASEL_E; w.bsel = BSEL_KP; w.aop = AOP_ADD;
      end
      5'd8: begin
        w.mop = MOP_MLO; w.aop = AOP_DSAT;
      end
      5'd9: w.mop = MOP_FIN;
      5'd10: begin
        w.mop = MOP_LD; w.asel = ASEL_E; w.bsel = BSEL_KI; w.aop = AOP_ADD;
      end
      5'd11: begin
        w.mop = MOP_MLO; w.aop = AOP_CLAMP;
      end
      5'd12: begin
        w.mop = MOP_FIN; w.aop = AOP_DIFF;
      end
      5'd13: begin
        w.mop = MOP_LD; w.asel = ASEL_ACC; w.bsel = BSEL_KB; w.frac_shift = 1'b1;
        w.aop = AOP_ISUM;
      end
      5'd14: w.mop = MOP_MLO;
      5'd15: w.mop = MOP_MHI;
      5'd16: w.mop = MOP_FIN;
      5'd17: begin
        w.aop = AOP_COMMIT; w.done = 1'b1;
      end
      5'd18: begin
        w.aop = AOP_HOLD; w.done = 1'b1;
      end
      default: w = UCW_NOP;
    endcase
    return w;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] x);
    logic fits;
    fits = (&x[WIDE_W-1:ACC_W-1]) || (~|x[WIDE_W-1:ACC_W-1]);
    if (fits) begin
      return x[ACC_W-1:0];
    end
    return {x[WIDE_W-1], {(ACC_W-1){~x[WIDE_W-1]}}};
  endfunction

endpackage

@@ hdl/pfd_in_if.sv @@
// Input channel: one error sample per beat.
interface pfd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pfd_pkg::SAMPLE_W-1:0] error_sample;
  logic                                 sample_valid;

  modport source(output valid, error_sample, sample_valid, input ready);
  modport sink(input valid, error_sample, sample_valid, output ready);
endinterface

@@ hdl/pfd_out_if.sv @@
// Result channel: one drive value per beat.
interface pfd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pfd_pkg::DRIVE_W-1:0] drive;
  logic                                clamped;
  logic                                held;

  modport source(output valid, drive, clamped, held, input ready);
  modport sink(input valid, drive, clamped, held, output ready);
endinterface

@@ hdl/pfd_cfg_if.sv @@
// Configuration write channel: register index and data per beat.
interface pfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pfd_pkg::CFG_IDX_W-1:0]    index;
  logic [pfd_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/pfd_cfg_regs.sv @@
// Configuration register file for gains, filter pole and drive limits.
module pfd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  pfd_cfg_if.sink       cfg_ch,
  output pfd_pkg::cfg_t cfg
);

  pfd_pkg::cfg_t cfg_r;
  pfd_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (pfd_pkg::reg_idx_t'(cfg_ch.index))
        pfd_pkg::REG_PROP_GAIN: cfg_nxt.kp    = cfg_ch.data[pfd_pkg::COEF_W-1:0];
        pfd_pkg::REG_KI_TS:     cfg_nxt.ki    = cfg_ch.data[pfd_pkg::COEF_W-1:0];
        pfd_pkg::REG_POLE:      cfg_nxt.pole  = cfg_ch.data[pfd_pkg::POLE_W-1:0];
        pfd_pkg::REG_KD:        cfg_nxt.kd    = cfg_ch.data[pfd_pkg::COEF_W-1:0];
        pfd_pkg::REG_KB:        cfg_nxt.kb    = cfg_ch.data[pfd_pkg::COEF_W-1:0];
        pfd_pkg::REG_LOWER:     cfg_nxt.lower = cfg_ch.data[pfd_pkg::DRIVE_W-1:0];
        pfd_pkg::REG_UPPER:     cfg_nxt.upper = cfg_ch.data[pfd_pkg::DRIVE_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp    <= '0;
      cfg_r.ki    <= '0;
      cfg_r.pole  <= {1'b1, {(pfd_pkg::POLE_W-1){1'b0}}};
      cfg_r.kd    <= '0;
      cfg_r.kb    <= '0;
      cfg_r.lower <= {1'b1, {(pfd_pkg::DRIVE_W-1){1'b0}}};
      cfg_r.upper <= {1'b0, {(pfd_pkg::DRIVE_W-1){1'b1}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/pfd_seq.sv @@
// Microcode sequencer: step counter, control store and conditional jump.
module pfd_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          sample_ok,
  input  logic          stall,
  output logic          busy,
  output pfd_pkg::ucw_t cw
);

  logic                      busy_r;
  logic                      busy_nxt;
  logic [pfd_pkg::PC_W-1:0] pc_r;
  logic [pfd_pkg::PC_W-1:0] pc_nxt;
  pfd_pkg::ucw_t             rom_w;
  logic                      issue;

  assign rom_w = pfd_pkg::ucode_rom(pc_r);
  assign issue = busy_r && !(rom_w.done && stall);
  assign cw    = issue ? rom_w : pfd_pkg::UCW_NOP;
  assign busy  = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (issue) begin
      if (rom_w.done) begin
        busy_nxt = 1'b0;
      end else if (rom_w.jump_inv && !sample_ok) begin
        pc_nxt = rom_w.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

@@ hdl/pfd_datapath.sv @@
// Datapath: shared partial-product multiplier, accumulator, controller state and result register.
module pfd_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pfd_pkg::ucw_t                        cw,
  input  pfd_pkg::cfg_t                        cfg,
  input  logic                                 load,
  input  logic signed [pfd_pkg::SAMPLE_W-1:0] in_error,
  input  logic                                 in_ok,
  input  logic                                 out_ready,
  output logic                                 sample_ok,
  output logic                                 stall,
  output logic                                 out_valid,
  output logic signed [pfd_pkg::DRIVE_W-1:0]  out_drive,
  output logic                                 out_clamped,
  output logic                                 out_held
);

  localparam int SW = pfd_pkg::SAMPLE_W;
  localparam int FW = pfd_pkg::FRAC_W;
  localparam int CW = pfd_pkg::COEF_W;
  localparam int AW = pfd_pkg::ACC_W;
  localparam int WW = pfd_pkg::WIDE_W;
  localparam int HW = pfd_pkg::HALF_W;
  localparam int PW = pfd_pkg::PROD_W;
  localparam int LW = pfd_pkg::LIM_W;
  localparam int DW = pfd_pkg::DRIVE_W;

  logic signed [SW-1:0] e_r, e_nxt;
  logic                 ok_r, ok_nxt;
  logic signed [AW-1:0] integ_r, integ_nxt;
  logic signed [AW-1:0] fd_r, fd_nxt;
  logic signed [SW-1:0] last_err_r, last_err_nxt;
  logic signed [DW-1:0] last_drive_r, last_drive_nxt;
  logic                 neg_r, neg_nxt;
  logic        [WW-1:0] amag_r, amag_nxt;
  logic        [CW-1:0] bmag_r, bmag_nxt;
  logic                 shift_r, shift_nxt;
  logic        [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] mres_r, mres_nxt;
  logic signed [WW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] dnew_r, dnew_nxt;
  logic signed [WW-1:0] uun_r, uun_nxt;
  logic signed [LW-1:0] usat_r, usat_nxt;
  logic                 clamp_r, clamp_nxt;
  logic signed [WW-1:0] isum_r, isum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] drive_r, drive_nxt;
  logic                 clamped_r, clamped_nxt;
  logic                 held_r, held_nxt;

  logic signed [SW:0]      derr;
  logic signed [WW-1:0]    a_val;
  logic signed [CW:0]      b_val;
  logic [pfd_pkg::POLE_W-1:0] alpha_eff;
  logic [HW+CW-1:0]        lo_pp;
  logic [WW-HW+CW-1:0]     hi_pp;
  logic [PW-1:0]           shifted;
  logic [PW-1:0]           cap;
  logic [PW-1:0]           mag;
  logic signed [WW-1:0]    hi_q;
  logic signed [WW-1:0]    lo_q;
  logic signed [WW-1:0]    umin;
  logic signed [WW-1:0]    usat_w;
  logic signed [AW-1:0]    dsat;
  logic signed [LW:0]      rnd;
  logic signed [DW-1:0]    drive_rnd;

  assign sample_ok   = ok_r;
  assign stall       = out_valid_r && !out_ready;
  assign out_valid   = out_valid_r;
  assign out_drive   = drive_r;
  assign out_clamped = clamped_r;
  assign out_held    = held_r;

  assign derr      = (SW+1)'(e_r) - (SW+1)'(last_err_r);
  assign alpha_eff = cfg.pole[pfd_pkg::POLE_W-1] ? {1'b1, {(pfd_pkg::POLE_W-1){1'b0}}} : cfg.pole;
  assign lo_pp     = amag_r[HW-1:0] * bmag_r;
  assign hi_pp     = amag_r[WW-1:HW] * bmag_r;
  assign shifted   = shift_r ? (prod_r >> FW) : prod_r;
  assign cap       = neg_r ? (PW'(1) << (AW-1)) : ((PW'(1) << (AW-1)) - PW'(1));
  assign mag       = (shifted > cap) ? cap : shifted;
  assign hi_q      = WW'($signed({cfg.upper, {FW{1'b0}}}));
  assign lo_q      = WW'($signed({cfg.lower, {FW{1'b0}}}));
  assign umin      = (acc_r < hi_q) ? acc_r : hi_q;
  assign usat_w    = (umin < lo_q) ? lo_q : umin;
  assign dsat      = pfd_pkg::sat_acc(acc_r);
  assign rnd       = (LW+1)'(usat_r) + (LW+1)'(2 ** (FW-1));
  assign drive_rnd = DW'(rnd >>> FW);

  always_comb begin
    case (cw.asel)
      pfd_pkg::ASEL_FD:   a_val = WW'(fd_r);
      pfd_pkg::ASEL_DERR: a_val = WW'(derr);
      pfd_pkg::ASEL_E:    a_val = WW'(e_r);
      pfd_pkg::ASEL_ACC:  a_val = acc_r;
      default:            a_val = acc_r;
    endcase
    case (cw.bsel)
      pfd_pkg::BSEL_ALPHA: b_val = (CW+1)'(alpha_eff);
      pfd_pkg::BSEL_KD:    b_val = (CW+1)'(cfg.kd);
      pfd_pkg::BSEL_KP:    b_val = (CW+1)'(cfg.kp);
      pfd_pkg::BSEL_KI:    b_val = (CW+1)'(cfg.ki);
      pfd_pkg::BSEL_KB:    b_val = (CW+1)'(cfg.kb);
      default:             b_val = (CW+1)'(cfg.kb);
    endcase
  end

  always_comb begin
    e_nxt          = e_r;
    ok_nxt         = ok_r;
    integ_nxt      = integ_r;
    fd_nxt         = fd_r;
    last_err_nxt   = last_err_r;
    last_drive_nxt = last_drive_r;
    neg_nxt        = neg_r;
    amag_nxt       = amag_r;
    bmag_nxt       = bmag_r;
    shift_nxt      = shift_r;
    prod_nxt       = prod_r;
    mres_nxt       = mres_r;
    acc_nxt        = acc_r;
    dnew_nxt       = dnew_r;
    uun_nxt        = uun_r;
    usat_nxt       = usat_r;
    clamp_nxt      = clamp_r;
    isum_nxt       = isum_r;
    drive_nxt      = drive_r;
    clamped_nxt    = clamped_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;

    if (load) begin
      e_nxt  = in_error;
      ok_nxt = in_ok;
    end

    case (cw.mop)
      pfd_pkg::MOP_LD: begin
        neg_nxt   = a_val[WW-1] ^ b_val[CW];
        amag_nxt  = a_val[WW-1] ? WW'(-a_val) : WW'(a_val);
        bmag_nxt  = b_val[CW] ? CW'(-b_val) : CW'(b_val);
        shift_nxt = cw.frac_shift;
      end
      pfd_pkg::MOP_MLO: prod_nxt = PW'(lo_pp);
      pfd_pkg::MOP_MHI: prod_nxt = prod_r + (PW'(hi_pp) << HW);
      pfd_pkg::MOP_FIN: mres_nxt = neg_r ? -AW'(mag) : AW'(mag);
      default: ;
    endcase

    case (cw.aop)
      pfd_pkg::AOP_SET: acc_nxt = WW'(mres_r);
      pfd_pkg::AOP_ADD: acc_nxt = acc_r + WW'(mres_r);
      pfd_pkg::AOP_DSAT: begin
        dnew_nxt = dsat;
        acc_nxt  = WW'(dsat) + WW'(integ_r);
      end
      pfd_pkg::AOP_CLAMP: begin
        uun_nxt   = acc_r;
        usat_nxt  = LW'(usat_w);
        clamp_nxt = (usat_w != acc_r);
      end
      pfd_pkg::AOP_DIFF: acc_nxt = WW'(usat_r) - uun_r;
      pfd_pkg::AOP_ISUM: isum_nxt = WW'(integ_r) + WW'(mres_r);
      pfd_pkg::AOP_COMMIT: begin
        integ_nxt      = pfd_pkg::sat_acc(isum_r + WW'(mres_r));
        fd_nxt         = dnew_r;
        last_err_nxt   = e_r;
        last_drive_nxt = drive_rnd;
        drive_nxt      = drive_rnd;
        clamped_nxt    = clamp_r;
        held_nxt       = 1'b0;
        out_valid_nxt  = 1'b1;
      end
      pfd_pkg::AOP_HOLD: begin
        drive_nxt     = last_drive_r;
        clamped_nxt   = 1'b0;
        held_nxt      = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      integ_r      <= '0;
      fd_r         <= '0;
      last_err_r   <= '0;
      last_drive_r <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      integ_r      <= integ_nxt;
      fd_r         <= fd_nxt;
      last_err_r   <= last_err_nxt;
      last_drive_r <= last_drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    ok_r      <= ok_nxt;
    neg_r     <= neg_nxt;
    amag_r    <= amag_nxt;
    bmag_r    <= bmag_nxt;
    shift_r   <= shift_nxt;
    prod_r    <= prod_nxt;
    mres_r    <= mres_nxt;
    acc_r     <= acc_nxt;
    dnew_r    <= dnew_nxt;
    uun_r     <= uun_nxt;
    usat_r    <= usat_nxt;
    clamp_r   <= clamp_nxt;
    isum_r    <= isum_nxt;
    drive_r   <= drive_nxt;
    clamped_r <= clamped_nxt;
    held_r    <= held_nxt;
  end

endmodule

@@ hdl/pid_filtered_derivative_antiwindup_top.sv @@
// A valid sample runs the whole microcode program and ends in a commit; an invalid one jumps to the hold step.
// One item is in work at a time; the final step waits while the result output is stalled.
// The microcode program runs five products through the shared
// 26x32 partial-product multiplier, two of them in two passes, plus accumulate steps.
// Synchronous active-low reset clears the controller state and restores register defaults.
module pid_filtered_derivative_antiwindup_top (
  input logic       clk,
  input logic       rst_n,
  pfd_in_if.sink    in_ch,
  pfd_out_if.source out_ch,
  pfd_cfg_if.sink   cfg_ch
);

  pfd_pkg::cfg_t cfg;
  pfd_pkg::ucw_t cw;
  logic          busy;
  logic          accept;
  logic          sample_ok;
  logic          stall;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;

  pfd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pfd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .sample_ok (sample_ok),
    .stall     (stall),
    .busy      (busy),
    .cw        (cw)
  );

  pfd_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cw          (cw),
    .cfg         (cfg),
    .load        (accept),
    .in_error    (in_ch.error_sample),
    .in_ok       (in_ch.sample_valid),
    .out_ready   (out_ch.ready),
    .sample_ok   (sample_ok),
    .stall       (stall),
    .out_valid   (out_ch.valid),
    .out_drive   (out_ch.drive),
    .out_clamped (out_ch.clamped),
    .out_held    (out_ch.held)
  );

endmodule

@@ hdl/pfd_checker.sv @@
// Port-level assertions for the PID controller, bound to the top level.
module pfd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [pfd_pkg::DRIVE_W-1:0]  out_drive,
  input logic                                 out_clamped,
  input logic                                 out_held
);

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("input still ready right after a beat was taken");

  a_result_from_work: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready)
  ) else $error("result appeared while no sample was in work");

  a_held_not_clamped: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_held) |-> !out_clamped
  ) else $error("held result also flagged as clamped");

  a_out_stable: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_drive) && $stable(out_clamped) && $stable(out_held))
  ) else $error("stalled result beat changed");

endmodule

bind pid_filtered_derivative_antiwindup_top pfd_checker u_pfd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_drive   (out_ch.drive),
  .out_clamped (out_ch.clamped),
  .out_held    (out_ch.held)
);
